// ===== hdl/bfds_pkg.sv =====
package bfds_pkg;

  // Default geometry
  localparam int MAX_ITEMS_DEF  = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int TAG_BITS_DEF   = 16;

  // Key format: unsigned 50-bit squared distance, saturating at KEY_MAX
  localparam int KEY_BITS = 50;
  localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};

  // An axis magnitude at or above 2^SQ_LIMIT_BITS saturates the key
  localparam int SQ_LIMIT_BITS = 25;

  // Configuration register map
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CAMERA_X = 2'd0,
    REG_CAMERA_Y = 2'd1,
    REG_CAMERA_Z = 2'd2
  } cfg_reg_e;

  // Per-cycle command broadcast to every sort cell
  typedef struct packed {
    logic insert;  // place the new entry in sorted position
    logic pop;     // shift every entry one cell toward the head
  } cell_ctrl_t;

endpackage

// ===== hdl/back_to_front_distance_sort.sv =====
// Output: out_valid rises once the transaction carrying last_item has passed
//   the 3-stage distance pipeline and been inserted into the cell chain.
// Throughput: loading runs at one item per cycle; the list then drains at one
//   result per cycle from the cell chain head while out_stall is low; input is
//   stalled from the last_item transaction until the final result is taken.
// Reset: synchronous, active high; clears the chain, item count, overflow flag
//   and camera registers (to zero). Stored tags and keys are not cleared.
module back_to_front_distance_sort #(
  parameter int MAX_ITEMS  = bfds_pkg::MAX_ITEMS_DEF,
  parameter int COORD_BITS = bfds_pkg::COORD_BITS_DEF,
  parameter int TAG_BITS   = bfds_pkg::TAG_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_write,
  input  logic [bfds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [TAG_BITS-1:0]                   item_tag,
  input  logic signed [COORD_BITS-1:0]          pos_x,
  input  logic signed [COORD_BITS-1:0]          pos_y,
  input  logic signed [COORD_BITS-1:0]          pos_z,
  input  logic                                  last_item,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [TAG_BITS-1:0]                   sorted_tag,
  output logic [bfds_pkg::KEY_BITS-1:0]         distance_sq,
  output logic                                  overflow,
  output logic                                  last_result
);
  import bfds_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);

  // ---------------------------------------------------------------------------
  // Camera registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] camera_x, camera_y, camera_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CAMERA_X: camera_x <= cfg_data;
        REG_CAMERA_Y: camera_y <= cfg_data;
        REG_CAMERA_Z: camera_z <= cfg_data;
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input handshake. busy covers the span from the last_item transaction
  // until the final result transaction of that list.
  // ---------------------------------------------------------------------------
  logic busy, busy_next;
  logic in_take, out_take;

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;

  // ---------------------------------------------------------------------------
  // Distance pipeline (3 stages)
  // ---------------------------------------------------------------------------
  logic                d_valid, d_last;
  logic [TAG_BITS-1:0] d_tag;
  logic [KEY_BITS-1:0] d_key;

  bfds_dist #(
    .COORD_BITS(COORD_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_take  (in_take),
    .in_tag   (item_tag),
    .in_x     (pos_x),
    .in_y     (pos_y),
    .in_z     (pos_z),
    .in_last  (last_item),
    .cam_x    (camera_x),
    .cam_y    (camera_y),
    .cam_z    (camera_z),
    .res_valid(d_valid),
    .res_tag  (d_tag),
    .res_last (d_last),
    .res_key  (d_key)
  );

  // ---------------------------------------------------------------------------
  // List control: fill count, overflow, drain
  // ---------------------------------------------------------------------------
  logic [CNT_BITS-1:0] item_count, item_count_next;
  logic                overflow_seen, overflow_seen_next;
  logic                draining, draining_next;
  logic                full, list_done;
  cell_ctrl_t          ctrl;

  assign full      = (item_count == CNT_BITS'(MAX_ITEMS));
  assign list_done = out_take && last_result;

  always_comb begin
    ctrl.insert = d_valid && !full;
    ctrl.pop    = out_take;

    busy_next          = busy;
    item_count_next    = item_count;
    overflow_seen_next = overflow_seen;
    draining_next      = draining;

    if (in_take && last_item) begin
      busy_next = 1'b1;
    end
    if (ctrl.insert) begin
      item_count_next = item_count + 1'b1;
    end
    if (d_valid && full) begin
      overflow_seen_next = 1'b1;  // item dropped, list still ends if marked last
    end
    if (d_valid && d_last) begin
      draining_next = 1'b1;
    end
    if (list_done) begin
      busy_next          = 1'b0;
      item_count_next    = '0;
      overflow_seen_next = 1'b0;
      draining_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      item_count    <= '0;
      overflow_seen <= 1'b0;
      draining      <= 1'b0;
    end else begin
      busy          <= busy_next;
      item_count    <= item_count_next;
      overflow_seen <= overflow_seen_next;
      draining      <= draining_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Insertion chain. Slot 0 and slot MAX_ITEMS+1 are empty boundaries;
  // cells occupy slots 1..MAX_ITEMS, slot 1 is the head (farthest).
  // ---------------------------------------------------------------------------
  logic                chain_valid [MAX_ITEMS+2];
  logic [TAG_BITS-1:0] chain_tag   [MAX_ITEMS+2];
  logic [KEY_BITS-1:0] chain_key   [MAX_ITEMS+2];
  logic                chain_shift [MAX_ITEMS+2];

  assign chain_valid[0]           = 1'b0;
  assign chain_tag[0]             = '0;
  assign chain_key[0]             = '0;
  assign chain_shift[0]           = 1'b0;
  assign chain_valid[MAX_ITEMS+1] = 1'b0;
  assign chain_tag[MAX_ITEMS+1]   = '0;
  assign chain_key[MAX_ITEMS+1]   = '0;
  assign chain_shift[MAX_ITEMS+1] = 1'b0;

  for (genvar i = 1; i <= MAX_ITEMS; i++) begin : g_cell
    bfds_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_tag   (d_tag),
      .new_key   (d_key),
      .prev_shift(chain_shift[i-1]),
      .prev_valid(chain_valid[i-1]),
      .prev_tag  (chain_tag[i-1]),
      .prev_key  (chain_key[i-1]),
      .next_valid(chain_valid[i+1]),
      .next_tag  (chain_tag[i+1]),
      .next_key  (chain_key[i+1]),
      .valid     (chain_valid[i]),
      .tag       (chain_tag[i]),
      .key       (chain_key[i]),
      .shift     (chain_shift[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Output: the head cell is the output register
  // ---------------------------------------------------------------------------
  assign out_valid   = draining && chain_valid[1];
  assign out_take    = out_valid && !out_stall;
  assign sorted_tag  = chain_tag[1];
  assign distance_sq = chain_key[1];
  assign overflow    = overflow_seen;
  assign last_result = !chain_valid[2];

endmodule

// ===== hdl/bfds_dist.sv =====
module bfds_dist #(
  parameter int COORD_BITS = bfds_pkg::COORD_BITS_DEF,
  parameter int TAG_BITS   = bfds_pkg::TAG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_take,
  input  logic        [TAG_BITS-1:0]          in_tag,
  input  logic signed [COORD_BITS-1:0]        in_x,
  input  logic signed [COORD_BITS-1:0]        in_y,
  input  logic signed [COORD_BITS-1:0]        in_z,
  input  logic                                in_last,
  input  logic signed [COORD_BITS-1:0]        cam_x,
  input  logic signed [COORD_BITS-1:0]        cam_y,
  input  logic signed [COORD_BITS-1:0]        cam_z,
  output logic                                res_valid,
  output logic        [TAG_BITS-1:0]          res_tag,
  output logic                                res_last,
  output logic        [bfds_pkg::KEY_BITS-1:0] res_key
);
  import bfds_pkg::*;

  localparam int MW = COORD_BITS + 1;          // magnitude of a difference
  localparam int QW = 2 * MW;                  // one square
  localparam int SW = QW + 2;                  // sum of three squares
  localparam int CW = (SW > KEY_BITS) ? SW : KEY_BITS + 1;

  // Stage 1: per-axis magnitude of the difference
  logic signed [MW-1:0] dx, dy, dz;
  logic        [MW-1:0] mx_next, my_next, mz_next;
  logic        [MW-1:0] mx, my, mz;
  logic                 v1, last1;
  logic [TAG_BITS-1:0]  tag1;

  always_comb begin
    dx = MW'(in_x) - MW'(cam_x);
    dy = MW'(in_y) - MW'(cam_y);
    dz = MW'(in_z) - MW'(cam_z);
    mx_next = dx[MW-1] ? MW'(-dx) : MW'(dx);
    my_next = dy[MW-1] ? MW'(-dy) : MW'(dy);
    mz_next = dz[MW-1] ? MW'(-dz) : MW'(dz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_take;
    end
    mx    <= mx_next;
    my    <= my_next;
    mz    <= mz_next;
    tag1  <= in_tag;
    last1 <= in_last;
  end

  // Stage 2: squares, one multiplier per axis
  logic [QW-1:0]       qx, qy, qz;
  logic                sat2, v2, last2;
  logic [TAG_BITS-1:0] tag2;
  logic                sat_next;

  always_comb begin
    sat_next = ((mx >> SQ_LIMIT_BITS) != '0) || ((my >> SQ_LIMIT_BITS) != '0) ||
               ((mz >> SQ_LIMIT_BITS) != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    qx    <= QW'(mx) * QW'(mx);
    qy    <= QW'(my) * QW'(my);
    qz    <= QW'(mz) * QW'(mz);
    sat2  <= sat_next;
    tag2  <= tag1;
    last2 <= last1;
  end

  // Stage 3: sum and clamp
  logic [CW-1:0]       sum;
  logic [KEY_BITS-1:0] key_next;

  always_comb begin
    sum = CW'(qx) + CW'(qy) + CW'(qz);
    if (sat2 || (sum > CW'(KEY_MAX))) begin
      key_next = KEY_MAX;
    end else begin
      key_next = KEY_BITS'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= v2;
    end
    res_key  <= key_next;
    res_tag  <= tag2;
    res_last <= last2;
  end

endmodule

// ===== hdl/bfds_cell.sv =====
module bfds_cell #(
  parameter int TAG_BITS = bfds_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfds_pkg::cell_ctrl_t          ctrl,
  input  logic [TAG_BITS-1:0]           new_tag,
  input  logic [bfds_pkg::KEY_BITS-1:0] new_key,
  input  logic                          prev_shift,
  input  logic                          prev_valid,
  input  logic [TAG_BITS-1:0]           prev_tag,
  input  logic [bfds_pkg::KEY_BITS-1:0] prev_key,
  input  logic                          next_valid,
  input  logic [TAG_BITS-1:0]           next_tag,
  input  logic [bfds_pkg::KEY_BITS-1:0] next_key,
  output logic                          valid,
  output logic [TAG_BITS-1:0]           tag,
  output logic [bfds_pkg::KEY_BITS-1:0] key,
  output logic                          shift
);
  import bfds_pkg::*;

  // New entry goes at or before this cell when strictly farther or this cell is
  // empty; ties stay behind older entries.
  assign shift = !valid || (new_key > key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= next_valid;
    end else if (ctrl.insert && shift) begin
      valid <= prev_shift ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      tag <= next_tag;
      key <= next_key;
    end else if (ctrl.insert && shift) begin
      tag <= prev_shift ? prev_tag : new_tag;
      key <= prev_shift ? prev_key : new_key;
    end
  end

endmodule
